>>> hw/rtl/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg: page frame allocator shared definitions
// Sizes, status codes, controller states and bitmap word helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pfa_pkg;

    // frame counts and the kernel reserved range
    localparam int FRAMES         = 32768;
    localparam int RESERVED_FIRST = 512;
    localparam int RESERVED_END   = 768;

    // index field width caps the number of frames that can exist
    localparam int INDEX_W       = 15;
    localparam int INDEX_LIMIT   = 1 << INDEX_W;
    localparam int FRAMES_ACTIVE = (FRAMES < INDEX_LIMIT) ? FRAMES : INDEX_LIMIT;

    // bitmap organized as 64-bit words
    localparam int WORD_BITS    = 64;
    localparam int BIT_W        = 6;
    localparam int WORD_AW      = INDEX_W - BIT_W;
    localparam int WORDS_MAX    = 1 << WORD_AW;
    localparam int WORDS_ACTIVE = (FRAMES_ACTIVE + WORD_BITS - 1) / WORD_BITS;

    localparam logic [WORD_AW-1:0] TOP_WORD  = WORD_AW'(WORDS_ACTIVE - 1);
    localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(WORDS_MAX - 1);

    // request codes
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef logic [WORD_BITS-1:0] word_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_OOM    = 2'd1,
        ST_DOUBLE = 2'd2
    } pfa_status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FREE_CHK,
        S_ALLOC_CHK,
        S_RESP
    } pfa_state_t;

    // bits of a word that name existing frames
    function automatic word_t word_valid_mask(input logic [WORD_AW-1:0] w);
        word_t m;
        int    f;
        m = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            f    = int'(w) * WORD_BITS + b;
            m[b] = (f < FRAMES_ACTIVE);
        end
        return m;
    endfunction

    // reset contents of a word: reserved frames marked used
    function automatic word_t word_reset_value(input logic [WORD_AW-1:0] w);
        word_t m;
        int    f;
        m = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            f    = int'(w) * WORD_BITS + b;
            m[b] = (f >= RESERVED_FIRST) && (f < RESERVED_END) && (f < FRAMES_ACTIVE);
        end
        return m;
    endfunction

    // position of the highest set bit
    function automatic logic [BIT_W-1:0] top_bit(input word_t v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            if (v[b]) begin
                r = BIT_W'(b);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/page_frame_allocator_top.sv
// ----------------------------------------------------------------------------
// page_frame_allocator_top: bitmap page frame allocator
// Allocates the highest free frame or frees a named frame, one transaction
// at a time, with the used marks held in a 512 x 64 synchronous memory.
// ----------------------------------------------------------------------------
// Flow: a free is checked in S_FREE_CHK, and an allocate scans the bitmap words
//   top down in S_ALLOC_CHK (1 to 512 words), one word read per cycle; the result
//   waits in S_RESP for the output slot and is then registered onto m_valid. A new
//   transaction is accepted only after S_RESP; a stalled result holds it off.
// Reset: a clear pass writes the reset bitmap (reserved frames used)
//   into the memory; s_ready stays low until it is done.
`timescale 1ns / 1ps
`default_nettype none

module page_frame_allocator_top
    import pfa_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_req_type,
    input  wire logic [INDEX_W-1:0] s_frame_index,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic      [INDEX_W-1:0] m_result_frame,
    output logic      [1:0]         m_status
);

    // controller state
    pfa_state_t          state_reg, state_next;
    logic [WORD_AW-1:0]  clr_reg, clr_next;
    logic [WORD_AW-1:0]  scan_reg, scan_next;

    // captured request
    logic                req_type_reg;
    logic [INDEX_W-1:0]  frame_index_reg;

    // pending result and output slot
    logic [INDEX_W-1:0]  res_frame_reg, res_frame_next;
    pfa_status_t         res_status_reg, res_status_next;
    logic                m_valid_reg, m_valid_next;
    logic [INDEX_W-1:0]  m_frame_reg, m_frame_next;
    pfa_status_t         m_status_reg, m_status_next;

    // memory ports
    word_t               mem [WORDS_MAX];
    word_t               mem_rdata_reg;
    logic                mem_we;
    logic [WORD_AW-1:0]  mem_waddr;
    word_t               mem_wdata;
    logic [WORD_AW-1:0]  mem_raddr;

    // word checks
    word_t               avail;
    logic [BIT_W-1:0]    hit_bit;
    logic                free_hit;
    logic                accept;
    logic                out_free;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign avail    = ~mem_rdata_reg & word_valid_mask(scan_reg);
    assign hit_bit  = top_bit(avail);
    assign free_hit = (int'(frame_index_reg) < FRAMES_ACTIVE)
                      && mem_rdata_reg[frame_index_reg[BIT_W-1:0]];

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (clr_reg == LAST_WORD) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    state_next = (s_req_type == REQ_FREE) ? S_FREE_CHK : S_ALLOC_CHK;
                end
            end
            S_FREE_CHK: begin
                state_next = S_RESP;
            end
            S_ALLOC_CHK: begin
                if (avail != '0 || scan_reg == '0) begin
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    // outputs and datapath control
    always_comb begin
        s_ready         = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = clr_reg;
        mem_wdata       = word_reset_value(clr_reg);
        mem_raddr       = scan_reg;
        clr_next        = clr_reg;
        scan_next       = scan_reg;
        res_frame_next  = res_frame_reg;
        res_status_next = res_status_reg;
        unique case (state_reg)
            S_CLEAR: begin
                mem_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
            end
            S_IDLE: begin
                s_ready   = 1'b1;
                scan_next = TOP_WORD;
                mem_raddr = (s_req_type == REQ_FREE) ? s_frame_index[INDEX_W-1:BIT_W]
                                                     : TOP_WORD;
            end
            S_FREE_CHK: begin
                mem_waddr = frame_index_reg[INDEX_W-1:BIT_W];
                mem_wdata = mem_rdata_reg;
                mem_wdata[frame_index_reg[BIT_W-1:0]] = 1'b0;
                if (free_hit) begin
                    mem_we          = 1'b1;
                    res_frame_next  = frame_index_reg;
                    res_status_next = ST_OK;
                end else begin
                    res_frame_next  = '0;
                    res_status_next = ST_DOUBLE;
                end
            end
            S_ALLOC_CHK: begin
                mem_waddr = scan_reg;
                mem_wdata = mem_rdata_reg;
                mem_wdata[hit_bit] = 1'b1;
                priority if (avail != '0) begin
                    mem_we          = 1'b1;
                    res_frame_next  = {scan_reg, hit_bit};
                    res_status_next = ST_OK;
                end else if (scan_reg == '0) begin
                    res_frame_next  = '0;
                    res_status_next = ST_OOM;
                end else begin
                    scan_next = scan_reg - 1'b1;
                    mem_raddr = scan_reg - 1'b1;
                end
            end
            S_RESP: begin
            end
            default: begin
            end
        endcase
    end

    // output slot
    always_comb begin
        m_valid_next  = m_valid_reg;
        m_frame_next  = m_frame_reg;
        m_status_next = m_status_reg;
        priority if (state_reg == S_RESP && out_free) begin
            m_valid_next  = 1'b1;
            m_frame_next  = res_frame_reg;
            m_status_next = res_status_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_type_reg    <= s_req_type;
            frame_index_reg <= s_frame_index;
        end
        scan_reg       <= scan_next;
        res_frame_reg  <= res_frame_next;
        res_status_reg <= res_status_next;
        m_frame_reg    <= m_frame_next;
        m_status_reg   <= m_status_next;
    end

    // bitmap memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    assign m_valid        = m_valid_reg;
    assign m_result_frame = m_frame_reg;
    assign m_status       = m_status_reg;

`ifndef SYNTH
    // captured request type steers the controller into the matching check
    a_req_path: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FREE_CHK) |-> (req_type_reg == REQ_FREE))
        else $error("free check entered for an allocate transaction");

    // the bitmap is only written during the clear pass or a check state
    a_no_idle_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE || state_reg == S_RESP) |-> !mem_we)
        else $error("bitmap written outside a check");

    // a failed transaction always reports frame zero
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> (m_result_frame == '0))
        else $error("error result carries a nonzero frame");

    // a successful result names an existing frame
    a_ok_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_OK) |-> (int'(m_result_frame) < FRAMES_ACTIVE))
        else $error("result frame out of range");

    // one transaction at a time: no new acceptance right after one
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second transaction accepted while busy");
`endif

endmodule

`default_nettype wire

>>> tb/page_frame_allocator_top_tb.sv
// ----------------------------------------------------------------------------
// page_frame_allocator_top_tb: self-checking bench for the page frame allocator
// Streams allocate and free transactions through the valid/ready channels.
// A bitmap predictor works out the expected frame and status for each
// accepted transaction, and a monitor compares every result in order. The
// run covers hand-picked corner cases and random batches of frees and
// allocations, some frees to random frames, then frees and retakes a few frames under stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module page_frame_allocator_top_tb;
    import pfa_pkg::*;

    localparam int     CLK_HALF     = 5;
    localparam int     RESET_CYCLES = 8;
    localparam int     MAX_WAIT     = 13;
    localparam int     RANDOM_ITEMS = 1620;
    localparam int     DRAIN_CYCLES = WORDS_MAX + 64;
    localparam longint CYCLE_LIMIT  = 40_000_000;
    localparam int     PRINT_LIMIT  = 40;

    typedef struct packed {
        logic               req_type;
        logic [INDEX_W-1:0] frame_index;
    } frame_req_t;

    typedef struct packed {
        logic [INDEX_W-1:0] frame;
        pfa_status_t        status;
    } frame_resp_t;

    logic               aclk           = 1'b0;
    logic               aresetn        = 1'b0;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic               s_req_type     = 1'b0;
    logic [INDEX_W-1:0] s_frame_index  = '0;
    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic [INDEX_W-1:0] m_result_frame;
    logic [1:0]         m_status;

    // predicted bitmap, and a scratch copy used to plan frees
    word_t       used_map [WORDS_MAX];
    word_t       plan_map [WORDS_MAX];

    frame_req_t  req_queue [$];
    frame_resp_t expected_q [$];
    frame_req_t  drv_item;
    int          drv_gap;
    bit          gap_drawn;
    int          rcv_wait;
    bit          send_gaps;
    bit          stall_gaps;
    int          mismatches  = 0;
    longint      cycle_count = 0;

    page_frame_allocator_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_frame_index  (s_frame_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_frame (m_result_frame),
        .m_status       (m_status)
    );

    // clock
    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_LIMIT) begin
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        end
    endtask

    // bitmap after reset: only the kernel reserved range is in use
    task automatic reset_bitmap();
        for (int w = 0; w < WORDS_MAX; w++) begin
            used_map[w] = '0;
        end
        for (int f = RESERVED_FIRST; f < RESERVED_END && f < FRAMES_ACTIVE; f++) begin
            used_map[f / WORD_BITS][f % WORD_BITS] = 1'b1;
        end
    endtask

    // apply one transaction to the predicted bitmap and return its result
    function automatic frame_resp_t serve_request(input frame_req_t rq);
        frame_resp_t rsp;
        word_t       avail;
        int          wi;
        int          bi;
        rsp.frame  = '0;
        rsp.status = ST_DOUBLE;
        if (rq.req_type == REQ_ALLOC) begin
            // highest free frame, scanning words from the top
            rsp.status = ST_OOM;
            for (int w = WORDS_ACTIVE - 1; w >= 0 && rsp.status == ST_OOM; w--) begin
                avail = ~used_map[w];
                if ((w + 1) * WORD_BITS > FRAMES_ACTIVE) begin
                    avail &= (word_t'(1) << (FRAMES_ACTIVE - w * WORD_BITS)) - 1;
                end
                if (avail != '0) begin
                    for (int b = WORD_BITS - 1; b >= 0 && rsp.status == ST_OOM; b--) begin
                        if (avail[b]) begin
                            used_map[w][b] = 1'b1;
                            rsp.frame      = INDEX_W'(w * WORD_BITS + b);
                            rsp.status     = ST_OK;
                        end
                    end
                end
            end
        end else begin
            // frames that do not exist count as free
            wi = int'(rq.frame_index) / WORD_BITS;
            bi = int'(rq.frame_index) % WORD_BITS;
            if (int'(rq.frame_index) < FRAMES_ACTIVE && used_map[wi][bi]) begin
                used_map[wi][bi] = 1'b0;
                rsp.frame        = rq.frame_index;
                rsp.status       = ST_OK;
            end
        end
        return rsp;
    endfunction

    function automatic void queue_request(input logic req_type,
                                          input logic [INDEX_W-1:0] frame_index);
        frame_req_t rq;
        rq.req_type    = req_type;
        rq.frame_index = frame_index;
        req_queue.push_back(rq);
    endfunction

    // a frame in use per the plan, taken out of the plan so it is freed once
    function automatic logic [INDEX_W-1:0] pick_used_frame();
        int live [$];
        int w;
        int b;
        for (int i = 0; i < WORDS_ACTIVE; i++) begin
            if (plan_map[i] != '0) begin
                live.push_back(i);
            end
        end
        if (live.size() == 0) begin
            return INDEX_W'($urandom);
        end
        w = live[$urandom_range(0, live.size() - 1)];
        do begin
            b = $urandom_range(0, WORD_BITS - 1);
        end while (!plan_map[w][b]);
        plan_map[w][b] = 1'b0;
        return INDEX_W'(w * WORD_BITS + b);
    endfunction

    // block until every queued transaction is accepted and answered
    task automatic wait_idle();
        do begin
            @(negedge aclk);
        end while (req_queue.size() != 0 || s_valid || expected_q.size() != 0);
    endtask

    // driver: presents queued transactions, after a random gap when send_gaps is set
    always @(posedge aclk) begin : driver
        logic busy;
        if (!aresetn) begin
            s_valid   <= 1'b0;
            gap_drawn = 1'b0;
            drv_gap   = 0;
        end else begin
            busy = s_valid;
            if (s_valid && s_ready) begin
                expected_q.push_back(serve_request(drv_item));
                busy = 1'b0;
            end
            if (!busy && req_queue.size() > 0) begin
                if (!gap_drawn) begin
                    drv_gap   = send_gaps ? $urandom_range(0, MAX_WAIT) : 0;
                    gap_drawn = 1'b1;
                end
                if (drv_gap == 0) begin
                    drv_item      = req_queue.pop_front();
                    gap_drawn     = 1'b0;
                    busy          = 1'b1;
                    s_req_type    <= drv_item.req_type;
                    s_frame_index <= drv_item.frame_index;
                end else begin
                    drv_gap--;
                end
            end
            s_valid <= busy;
        end
    end

    // monitor: checks each result transaction and, when stall_gaps is set, stalls m_ready at random
    always @(posedge aclk) begin : monitor
        frame_resp_t want;
        if (!aresetn) begin
            m_ready  <= 1'b0;
            rcv_wait = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result frame %0d status %0d",
                                              m_result_frame, m_status));
                end else begin
                    want = expected_q.pop_front();
                    if (m_result_frame !== want.frame) begin
                        report_mismatch($sformatf("result_frame %0d, predicted %0d",
                                                  m_result_frame, want.frame));
                    end
                    if (m_status !== want.status) begin
                        report_mismatch($sformatf("status %0d, predicted %0d (frame %0d)",
                                                  m_status, want.status, want.frame));
                    end
                end
                rcv_wait = stall_gaps ? $urandom_range(0, MAX_WAIT) : 0;
            end else if (m_valid && rcv_wait > 0) begin
                rcv_wait--;
            end
            m_ready <= (rcv_wait == 0);
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[page_frame_allocator_top] ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int n_random;
        int batch;
        int alloc_pct;
        reset_bitmap();
        send_gaps  = 1'b0;
        stall_gaps = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // corner cases: top frames, reserved range edges, double frees
        queue_request(REQ_ALLOC, '1);
        queue_request(REQ_ALLOC, '0);
        queue_request(REQ_FREE, INDEX_W'(FRAMES_ACTIVE - 1));
        queue_request(REQ_FREE, INDEX_W'(FRAMES_ACTIVE - 1));
        queue_request(REQ_FREE, '0);
        queue_request(REQ_FREE, INDEX_W'(RESERVED_FIRST - 1));
        queue_request(REQ_FREE, INDEX_W'(RESERVED_FIRST));
        queue_request(REQ_FREE, INDEX_W'(RESERVED_END - 1));
        queue_request(REQ_FREE, INDEX_W'(RESERVED_END));
        queue_request(REQ_FREE, INDEX_W'(RESERVED_FIRST));
        queue_request(REQ_ALLOC, 15'h5555);
        queue_request(REQ_ALLOC, 15'h2aaa);
        queue_request(REQ_FREE, INDEX_W'(FRAMES_ACTIVE - 2));
        queue_request(REQ_FREE, INDEX_W'(FRAMES_ACTIVE - 3));
        queue_request(REQ_FREE, INDEX_W'(FRAMES_ACTIVE - 1));
        queue_request(REQ_FREE, 15'h2aaa);
        queue_request(REQ_FREE, 15'h5555);
        wait_idle();

        // random batches; sender holds off between batches until drained
        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            batch      = $urandom_range(5, 40);
            alloc_pct  = 30 + 20 * $urandom_range(0, 2);
            send_gaps  = $urandom_range(0, 1);
            stall_gaps = $urandom_range(0, 1);
            for (int w = 0; w < WORDS_MAX; w++) begin
                plan_map[w] = used_map[w];
            end
            for (int i = 0; i < batch; i++) begin
                if ($urandom_range(0, 99) < alloc_pct) begin
                    queue_request(REQ_ALLOC, INDEX_W'($urandom));
                end else if ($urandom_range(0, 4) == 0) begin
                    queue_request(REQ_FREE, INDEX_W'($urandom));
                end else begin
                    queue_request(REQ_FREE, pick_used_frame());
                end
            end
            n_random += batch;
            wait_idle();
        end

        // free and retake a few frames with gaps and stalls on both sides
        send_gaps  = 1'b1;
        stall_gaps = 1'b1;
        queue_request(REQ_FREE, INDEX_W'(RESERVED_FIRST));
        queue_request(REQ_FREE, '0);
        queue_request(REQ_FREE, INDEX_W'(FRAMES_ACTIVE - 1));
        queue_request(REQ_ALLOC, '0);
        queue_request(REQ_ALLOC, '1);
        queue_request(REQ_ALLOC, '0);
        queue_request(REQ_ALLOC, '1);
        queue_request(REQ_FREE, '0);
        queue_request(REQ_FREE, '0);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_q.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
        end
        if (mismatches == 0) begin
            $display("[page_frame_allocator_top] OK");
        end else begin
            $display("[page_frame_allocator_top] ERROR");
        end
        $finish;
    end

endmodule
